/* design/wals_pkg.sv */
// ----------------------------------------------------------------------------
// wals_pkg
// shared types and constants of the windowed audio level statistics unit
// ----------------------------------------------------------------------------
package wals_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COUNT_BITS  = 40;
    localparam int WIN_BITS    = 20;
    localparam int SUM_BITS    = 64;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS;
    localparam int WLEN_BITS   = 19;
    localparam int RUN_BITS    = 16;
    localparam int LIMIT_BITS  = WLEN_BITS + RUN_BITS;
    localparam int CFG_BITS    = 19;
    localparam int ADDR_BITS   = 1;
    localparam int CNT_BITS    = 6;
    localparam int DIV_STEPS   = SUM_BITS;
    localparam int ROOT_STEPS  = SUM_BITS / 2;

    localparam logic [WLEN_BITS-1:0] WLEN_RESET = WLEN_BITS'(48000);

    localparam logic [ADDR_BITS-1:0] CFG_WINDOW_LENGTH = 1'b0;
    localparam logic [ADDR_BITS-1:0] CFG_RUN_SECONDS   = 1'b1;

    localparam logic MODE_SAMPLE  = 1'b0;
    localparam logic MODE_REPORT  = 1'b1;
    localparam logic SCOPE_WINDOW = 1'b0;
    localparam logic SCOPE_TOTAL  = 1'b1;

    typedef struct packed {
        logic                          mode;
        logic signed [SAMPLE_BITS-1:0] sample;
    } in_t;

    typedef struct packed {
        logic                          scope;
        logic [COUNT_BITS-1:0]         frame_count;
        logic [SAMPLE_BITS-1:0]        rms_level;
        logic [SAMPLE_BITS-1:0]        peak_level;
        logic signed [SAMPLE_BITS-1:0] min_level;
        logic signed [SAMPLE_BITS-1:0] max_level;
        logic                          finished;
        logic                          last;
    } out_t;

    typedef struct packed {
        logic load_item;
        logic square;
        logic accum;
        logic snap_total;
        logic snap_window;
        logic snap_fin;
        logic snap_last;
        logic set_done;
        logic div_step;
        logic root_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic run_done;
        logic win_hit;
        logic run_hit;
        logic div_last;
        logic root_last;
        logic out_free;
    } status_t;

endpackage

/* design/wals_ctrl.sv */
// ----------------------------------------------------------------------------
// wals_ctrl
// sequencer: sample update, report division and root, result hand-off
// ----------------------------------------------------------------------------
module wals_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_mode,
    output logic             s_ready,
    input  wals_pkg::status_t st,
    output wals_pkg::cmd_t    cmd
);
    import wals_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SQ   = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_CHK  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_ROOT = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_mode == MODE_REPORT) begin
                        cmd.snap_total = 1'b1;
                        cmd.snap_fin   = st.run_done;
                        cmd.snap_last  = 1'b1;
                        state_next     = S_DIV;
                    end else if (!st.run_done) begin
                        cmd.load_item = 1'b1;
                        state_next    = S_SQ;
                    end
                end
            end
            S_SQ: begin
                cmd.square = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.accum  = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (st.win_hit) begin
                    cmd.snap_window = 1'b1;
                    cmd.snap_last   = !st.run_hit;
                    cmd.set_done    = st.run_hit;
                    pend_next       = st.run_hit;
                    state_next      = S_DIV;
                end else if (st.run_hit) begin
                    cmd.snap_total = 1'b1;
                    cmd.snap_fin   = 1'b1;
                    cmd.snap_last  = 1'b1;
                    cmd.set_done   = 1'b1;
                    state_next     = S_DIV;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (st.div_last) begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT: begin
                cmd.root_step = 1'b1;
                if (st.root_last) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    if (pend_reg) begin
                        cmd.snap_total = 1'b1;
                        cmd.snap_fin   = 1'b1;
                        cmd.snap_last  = 1'b1;
                        pend_next      = 1'b0;
                        state_next     = S_DIV;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

/* design/wals_dp.sv */
// ----------------------------------------------------------------------------
// wals_dp
// statistic sets, serial divider, serial square root and result register
// ----------------------------------------------------------------------------
module wals_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [wals_pkg::ADDR_BITS-1:0]       cfg_addr,
    input  logic [wals_pkg::CFG_BITS-1:0]        cfg_wdata,
    input  logic signed [wals_pkg::SAMPLE_BITS-1:0] s_sample,
    input  wals_pkg::cmd_t                       cmd,
    output wals_pkg::status_t                    st,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output wals_pkg::out_t                       m_data
);
    import wals_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [WLEN_BITS-1:0]  wlen_reg;
    logic [RUN_BITS-1:0]   run_reg;
    logic [COUNT_BITS-1:0] mark_reg;
    logic                  done_reg;

    logic signed [SAMPLE_BITS-1:0] smp_reg;
    logic [SAMPLE_BITS-1:0]        mag_reg;
    logic [SQ_BITS-1:0]            sq_reg;
    logic [LIMIT_BITS-1:0]         limit_reg;

    logic [COUNT_BITS-1:0]         tot_frames_reg;
    logic [SUM_BITS-1:0]           tot_sum_reg;
    logic [SAMPLE_BITS-1:0]        tot_peak_reg;
    logic signed [SAMPLE_BITS-1:0] tot_min_reg, tot_max_reg;
    logic [WIN_BITS-1:0]           win_frames_reg;
    logic [SUM_BITS-1:0]           win_sum_reg;
    logic [SAMPLE_BITS-1:0]        win_peak_reg;
    logic signed [SAMPLE_BITS-1:0] win_min_reg, win_max_reg;

    logic                          rep_scope_reg, rep_fin_reg, rep_last_reg;
    logic [COUNT_BITS-1:0]         rep_frames_reg;
    logic [SAMPLE_BITS-1:0]        rep_peak_reg;
    logic signed [SAMPLE_BITS-1:0] rep_min_reg, rep_max_reg;

    logic [SUM_BITS-1:0]   quo_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [SUM_BITS-1:0]   op_reg, res_reg, one_reg;

    out_t out_reg;
    logic out_valid_reg;

    logic [WLEN_BITS-1:0]  eff_len, cfg_len;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SUM_BITS:0]     tot_add, win_add;
    logic [COUNT_BITS:0]   mark_add;
    logic [COUNT_BITS:0]   rem_sh;
    logic                  div_ge;
    logic [SUM_BITS-1:0]   quo_next;
    logic [SUM_BITS-1:0]   trial;
    logic                  rep_empty;

    assign eff_len  = (wlen_reg == '0) ? WLEN_BITS'(1) : wlen_reg;
    assign cfg_len  = (cfg_wdata[WLEN_BITS-1:0] == '0) ? WLEN_BITS'(1)
                                                       : cfg_wdata[WLEN_BITS-1:0];
    assign mag      = smp_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(-smp_reg) : smp_reg;
    assign tot_add  = {1'b0, tot_sum_reg} + (SUM_BITS+1)'(sq_reg);
    assign win_add  = {1'b0, win_sum_reg} + (SUM_BITS+1)'(sq_reg);
    assign mark_add = {1'b0, mark_reg} + (COUNT_BITS+1)'(eff_len);
    assign rem_sh   = {rem_reg, quo_reg[SUM_BITS-1]};
    assign div_ge   = rem_sh >= {1'b0, rep_frames_reg};
    assign quo_next = {quo_reg[SUM_BITS-2:0], div_ge};
    assign trial    = res_reg + one_reg;
    assign rep_empty = (rep_frames_reg == '0);

    assign st.run_done  = done_reg;
    assign st.win_hit   = tot_frames_reg >= mark_reg;
    assign st.run_hit   = (run_reg != '0) && (tot_frames_reg >= COUNT_BITS'(limit_reg));
    assign st.div_last  = (cnt_reg == CNT_BITS'(DIV_STEPS-1));
    assign st.root_last = (cnt_reg == CNT_BITS'(ROOT_STEPS-1));
    assign st.out_free  = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // configuration, report mark and run flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg <= WLEN_RESET;
            run_reg  <= '0;
            mark_reg <= COUNT_BITS'(WLEN_RESET);
            done_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_WINDOW_LENGTH: begin
                        wlen_reg <= cfg_wdata[WLEN_BITS-1:0];
                        if (tot_frames_reg == '0) begin
                            mark_reg <= COUNT_BITS'(cfg_len);
                        end
                    end
                    CFG_RUN_SECONDS: begin
                        run_reg <= cfg_wdata[RUN_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.snap_window) begin
                mark_reg <= mark_add[COUNT_BITS] ? '1 : mark_add[COUNT_BITS-1:0];
            end
            if (cmd.set_done) begin
                done_reg <= 1'b1;
            end
        end
    end

    // sample path
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            smp_reg <= s_sample;
        end
        if (cmd.square) begin
            mag_reg   <= mag;
            sq_reg    <= SQ_BITS'(mag) * SQ_BITS'(mag);
            limit_reg <= LIMIT_BITS'(run_reg) * LIMIT_BITS'(eff_len);
        end
    end

    // statistic sets
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tot_frames_reg <= '0;
            tot_sum_reg    <= '0;
            tot_peak_reg   <= '0;
            tot_min_reg    <= SMAX;
            tot_max_reg    <= SMIN;
            win_frames_reg <= '0;
            win_sum_reg    <= '0;
            win_peak_reg   <= '0;
            win_min_reg    <= SMAX;
            win_max_reg    <= SMIN;
        end else if (cmd.accum) begin
            if (tot_frames_reg != '1) tot_frames_reg <= tot_frames_reg + 1'b1;
            tot_sum_reg <= tot_add[SUM_BITS] ? '1 : tot_add[SUM_BITS-1:0];
            if (mag_reg > tot_peak_reg) tot_peak_reg <= mag_reg;
            if (smp_reg < tot_min_reg) tot_min_reg <= smp_reg;
            if (smp_reg > tot_max_reg) tot_max_reg <= smp_reg;
            if (win_frames_reg != '1) win_frames_reg <= win_frames_reg + 1'b1;
            win_sum_reg <= win_add[SUM_BITS] ? '1 : win_add[SUM_BITS-1:0];
            if (mag_reg > win_peak_reg) win_peak_reg <= mag_reg;
            if (smp_reg < win_min_reg) win_min_reg <= smp_reg;
            if (smp_reg > win_max_reg) win_max_reg <= smp_reg;
        end else if (cmd.snap_window) begin
            win_frames_reg <= '0;
            win_sum_reg    <= '0;
            win_peak_reg   <= '0;
            win_min_reg    <= SMAX;
            win_max_reg    <= SMIN;
        end
    end

    // report snapshot, divider and root
    always_ff @(posedge aclk) begin
        if (cmd.snap_total || cmd.snap_window) begin
            rep_scope_reg <= cmd.snap_total ? SCOPE_TOTAL : SCOPE_WINDOW;
            rep_fin_reg   <= cmd.snap_fin;
            rep_last_reg  <= cmd.snap_last;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            if (cmd.snap_total) begin
                rep_frames_reg <= tot_frames_reg;
                rep_peak_reg   <= tot_peak_reg;
                rep_min_reg    <= tot_min_reg;
                rep_max_reg    <= tot_max_reg;
                quo_reg        <= tot_sum_reg;
            end else begin
                rep_frames_reg <= COUNT_BITS'(win_frames_reg);
                rep_peak_reg   <= win_peak_reg;
                rep_min_reg    <= win_min_reg;
                rep_max_reg    <= win_max_reg;
                quo_reg        <= win_sum_reg;
            end
        end else if (cmd.div_step) begin
            rem_reg <= div_ge ? COUNT_BITS'(rem_sh - {1'b0, rep_frames_reg})
                              : rem_sh[COUNT_BITS-1:0];
            quo_reg <= quo_next;
            if (st.div_last) begin
                op_reg  <= quo_next;
                res_reg <= '0;
                one_reg <= {2'b01, {(SUM_BITS-2){1'b0}}};
                cnt_reg <= '0;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end else if (cmd.root_step) begin
            if (op_reg >= trial) begin
                op_reg  <= op_reg - trial;
                res_reg <= (res_reg >> 1) + one_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            one_reg <= one_reg >> 2;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.scope       <= rep_scope_reg;
            out_reg.frame_count <= rep_frames_reg;
            out_reg.rms_level   <= rep_empty ? '0 : res_reg[SAMPLE_BITS-1:0];
            out_reg.peak_level  <= rep_peak_reg;
            out_reg.min_level   <= rep_empty ? '0 : rep_min_reg;
            out_reg.max_level   <= rep_empty ? '0 : rep_max_reg;
            out_reg.finished    <= rep_fin_reg;
            out_reg.last        <= rep_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

/* design/windowed_audio_level_stats_unit.sv */
// ----------------------------------------------------------------------------
// windowed_audio_level_stats_unit
// A plain sample (mode 0) passes the square, accumulate and report check
// states in turn before the input is ready again. Every report runs a
// 64-step serial divider (sum of squares over frames), a 32-step serial
// square root and then loads the result register. A report request
// (mode 1) holds the input through one report; a sample that closes a
// window or the run, through its check and one report; one that closes
// both, through two. Any wait on an unclaimed result register adds to
// this. Results wait in an output register, so the next report's work
// runs while the previous result is still unclaimed.
// ----------------------------------------------------------------------------
module windowed_audio_level_stats_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  wals_pkg::in_t                  s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output wals_pkg::out_t                 m_data,
    input  logic                           cfg_we,
    input  logic [wals_pkg::ADDR_BITS-1:0] cfg_addr,
    input  logic [wals_pkg::CFG_BITS-1:0]  cfg_wdata
);
    import wals_pkg::*;

    cmd_t    cmd;
    status_t st;

    wals_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_data.mode),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    wals_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_sample  (s_data.sample),
        .cmd       (cmd),
        .st        (st),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // empty set reads as zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_count == '0) |->
        (m_data.rms_level == '0 && m_data.min_level == '0 && m_data.max_level == '0))
        else $error("empty set with nonzero levels");

    // window results never carry finished
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.scope == SCOPE_WINDOW) |-> !m_data.finished)
        else $error("window result marked finished");

    // report request occupies the block
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.mode == MODE_REPORT) |=> !s_ready)
        else $error("ready during report");

endmodule

/* test/tb_windowed_audio_level_stats_unit.sv */
// ----------------------------------------------------------------------------
// tb_windowed_audio_level_stats_unit
// Drives signed samples and total report requests through the level meter
// under several window and run length settings, predicts every window and
// total report in the bench and checks each result field by field.
// ----------------------------------------------------------------------------
module tb_windowed_audio_level_stats_unit;
    import wals_pkg::*;

    localparam int          STALL_LIMIT = 6000;
    localparam int          DRAIN_WAIT  = 250;
    localparam int          SMAX        = 8388607;
    localparam int          SMIN        = -8388608;
    localparam longint unsigned CMAX    = (64'd1 << COUNT_BITS) - 1;
    localparam longint unsigned WMAX    = (64'd1 << WIN_BITS) - 1;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_t                  s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_t                 m_data;
    logic                 cfg_we = 1'b0;
    logic [ADDR_BITS-1:0] cfg_addr = '0;
    logic [CFG_BITS-1:0]  cfg_wdata = '0;

    windowed_audio_level_stats_unit dut (.*);

    always #10 aclk = ~aclk;

    // level meter state as the bench sees it
    typedef struct {
        longint unsigned frames;
        longint unsigned sum_sq;
        int              peak;
        int              lo;
        int              hi;
    } level_acc_t;

    level_acc_t      total_acc, window_acc;
    longint unsigned win_len_reg, run_sec_reg, report_mark;
    bit              run_stopped;

    in_t  request_queue[$];
    out_t pending_reports[$];
    int   send_idle_pct, recv_idle_pct, recv_hold;
    bit   request_taken;
    int   stall_cycles, errors, requests_sent, window_reports, total_reports;

    function automatic level_acc_t cleared_acc();
        level_acc_t a;
        a.frames = 0; a.sum_sq = 0; a.peak = 0; a.lo = SMAX; a.hi = SMIN;
        return a;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic level_acc_t fold_level(level_acc_t a, int v, longint unsigned cap);
        longint unsigned mag, sq;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        sq = mag * mag;
        a.sum_sq = (a.sum_sq > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                             : a.sum_sq + sq;
        if (int'(mag) > a.peak) a.peak = int'(mag);
        if (v < a.lo) a.lo = v;
        if (v > a.hi) a.hi = v;
        if (a.frames < cap) a.frames++;
        return a;
    endfunction

    function automatic out_t level_report(level_acc_t a, logic scope, logic fin);
        out_t r;
        bit   empty;
        empty = (a.frames == 0);
        r.scope       = scope;
        r.frame_count = a.frames[COUNT_BITS-1:0];
        r.rms_level   = empty ? '0 : SAMPLE_BITS'(int_sqrt(a.sum_sq / a.frames));
        r.peak_level  = SAMPLE_BITS'(a.peak);
        r.min_level   = empty ? '0 : SAMPLE_BITS'(a.lo);
        r.max_level   = empty ? '0 : SAMPLE_BITS'(a.hi);
        r.finished    = fin;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic longint unsigned eff_len();
        return (win_len_reg == 0) ? 1 : win_len_reg;
    endfunction

    task automatic predict_levels(in_t req);
        out_t r;
        out_t win_rep, tot_rep;
        bit   win_due, tot_due;
        win_due = 1'b0;
        tot_due = 1'b0;
        if (req.mode == MODE_REPORT) begin
            r = level_report(total_acc, SCOPE_TOTAL, run_stopped);
            r.last = 1'b1;
            pending_reports.push_back(r);
            total_reports++;
            return;
        end
        if (run_stopped) return;
        total_acc = fold_level(total_acc, int'(req.sample), CMAX);
        window_acc = fold_level(window_acc, int'(req.sample), WMAX);
        if (total_acc.frames >= report_mark) begin
            win_rep = level_report(window_acc, SCOPE_WINDOW, 1'b0);
            win_due = 1'b1;
            window_reports++;
            window_acc = cleared_acc();
            report_mark = (report_mark > CMAX - eff_len()) ? CMAX : report_mark + eff_len();
        end
        if (run_sec_reg != 0 && total_acc.frames >= run_sec_reg * eff_len()) begin
            run_stopped = 1'b1;
            tot_rep = level_report(total_acc, SCOPE_TOTAL, 1'b1);
            tot_due = 1'b1;
            total_reports++;
        end
        if (win_due) begin
            win_rep.last = !tot_due;
            pending_reports.push_back(win_rep);
        end
        if (tot_due) begin
            tot_rep.last = 1'b1;
            pending_reports.push_back(tot_rep);
        end
    endtask

    task automatic compare_report(out_t got);
        out_t want;
        if (pending_reports.size() == 0) begin
            $error("result with no expectation: %p", got);
            errors++;
            return;
        end
        want = pending_reports.pop_front();
        if (got.scope !== want.scope) begin
            $error("scope exp %0d got %0d", want.scope, got.scope); errors++;
        end
        if (got.frame_count !== want.frame_count) begin
            $error("frame_count exp %0d got %0d", want.frame_count, got.frame_count);
            errors++;
        end
        if (got.rms_level !== want.rms_level) begin
            $error("rms_level exp %0d got %0d", want.rms_level, got.rms_level); errors++;
        end
        if (got.peak_level !== want.peak_level) begin
            $error("peak_level exp %0d got %0d", want.peak_level, got.peak_level); errors++;
        end
        if (got.min_level !== want.min_level) begin
            $error("min_level exp %0d got %0d", want.min_level, got.min_level); errors++;
        end
        if (got.max_level !== want.max_level) begin
            $error("max_level exp %0d got %0d", want.max_level, got.max_level); errors++;
        end
        if (got.finished !== want.finished) begin
            $error("finished exp %0d got %0d", want.finished, got.finished); errors++;
        end
        if (got.last !== want.last) begin
            $error("last exp %0d got %0d", want.last, got.last); errors++;
        end
    endtask

    // monitor: accept on rising edge, predict and check
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                compare_report(m_data);
            end
            if (s_valid && s_ready) begin
                predict_levels(s_data);
                request_taken = 1'b1;
                requests_sent++;
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // request driver
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || request_taken)) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= request_queue.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
        request_taken = 1'b0;
    end

    // result receiver with optional long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic in_t make_request(logic mode, int v);
        in_t r;
        r.mode = mode;
        r.sample = SAMPLE_BITS'(v);
        return r;
    endfunction

    function automatic in_t random_request();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10) return make_request(MODE_REPORT, $urandom);
        if (sel < 16) return make_request(MODE_SAMPLE, SMIN);
        if (sel < 22) return make_request(MODE_SAMPLE, SMAX);
        if (sel < 30) return make_request(MODE_SAMPLE, $urandom_range(8) - 4);
        return make_request(MODE_SAMPLE, $urandom);
    endfunction

    task automatic queue_random(int n);
        repeat (n) request_queue.push_back(random_request());
    endtask

    task automatic wait_idle();
        while (request_queue.size() != 0 || s_valid || pending_reports.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic write_reg(logic [ADDR_BITS-1:0] addr, int unsigned value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= CFG_BITS'(value);
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (addr == CFG_WINDOW_LENGTH) begin
            win_len_reg = value & 32'h7FFFF;
            if (total_acc.frames == 0) report_mark = eff_len();
        end else begin
            run_sec_reg = value & 32'hFFFF;
        end
    endtask

    initial begin
        int corner_vals[8] = '{SMIN, SMAX, 0, -1, 1, SMIN + 1, SMAX - 1, 4096};
        total_acc = cleared_acc();
        window_acc = cleared_acc();
        win_len_reg = 48000;
        run_sec_reg = 0;
        report_mark = 48000;
        run_stopped = 1'b0;
        send_idle_pct = 22;
        recv_idle_pct = 46;
        recv_hold = 0;
        stall_cycles = 0;
        errors = 0;
        requests_sent = 0;
        window_reports = 0;
        total_reports = 0;
        request_taken = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // window length set before any sample also moves the first mark
        write_reg(CFG_WINDOW_LENGTH, 4);
        write_reg(CFG_RUN_SECONDS, 0);
        request_queue.push_back(make_request(MODE_REPORT, 0));
        foreach (corner_vals[i])
            request_queue.push_back(make_request(MODE_SAMPLE, corner_vals[i]));
        request_queue.push_back(make_request(MODE_REPORT, -1));
        repeat (4) request_queue.push_back(make_request(MODE_SAMPLE, SMIN));
        repeat (4) request_queue.push_back(make_request(MODE_SAMPLE, SMAX));
        request_queue.push_back(make_request(MODE_REPORT, SMAX));
        queue_random(560);
        wait (requests_sent > 200);
        recv_hold = 400;
        wait_idle();

        // zero length acts as one; large run limit never reached
        send_idle_pct = 46;
        recv_idle_pct = 22;
        write_reg(CFG_WINDOW_LENGTH, 0);
        write_reg(CFG_RUN_SECONDS, 65535);
        queue_random(450);
        wait_idle();

        // widest window field, mark then leaps far ahead
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_WINDOW_LENGTH, 384000);
        write_reg(CFG_RUN_SECONDS, 0);
        queue_random(150);
        wait_idle();
        write_reg(CFG_WINDOW_LENGTH, 32'h7FFFF);
        queue_random(100);
        wait_idle();

        // run limit a few dozen frames ahead, then samples are dropped
        write_reg(CFG_WINDOW_LENGTH, 3);
        write_reg(CFG_RUN_SECONDS, int'(total_acc.frames / 3) + 20);
        queue_random(340);
        wait_idle();

        $display("run covered %0d requests, %0d window and %0d total reports",
                 requests_sent, window_reports, total_reports);
        $display("window lengths 0..524287, run limits 0..65535, run stop %0s",
                 run_stopped ? "reached" : "missed");
        if (errors == 0 && run_stopped) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
